[rtl/core/nla_pkg.sv]
// ----------------------------------------------------------------------------
// nla_pkg
// Shared constants and controller/datapath interface types for the
// newline line assembler.
// ----------------------------------------------------------------------------
package nla_pkg;

	localparam int unsigned MAX_LINE_DEF = 64;

	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

	// controller -> datapath
	typedef struct packed {
		logic wr;     // store incoming word at line end
		logic ovf;    // overflow: clear line, enter drop mode
		logic lf;     // newline: clear line and drop, latch emit length
		logic fetch;  // read next stored word into output register
	} nla_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_lf;      // incoming word is a newline
		logic dropping;
		logic full;       // line holds MAX_LINE words
		logic line_empty; // nothing to emit after CR strip
		logic last;       // output register holds final word of line
	} nla_sts_t;

endpackage

[rtl/core/nla_datapath.sv]
// ----------------------------------------------------------------------------
// nla_datapath
// Line store, length counter, drop flag, read pointer and output register.
// ----------------------------------------------------------------------------
module nla_datapath #(
	parameter int unsigned MAX_LINE = nla_pkg::MAX_LINE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  nla_pkg::nla_cmd_t cmd,
	output nla_pkg::nla_sts_t sts,
	output logic [7:0]       out_byte,
	output logic             last_of_line
);
	import nla_pkg::*;

	localparam int unsigned IDX_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);

	logic [7:0]       mem [MAX_LINE];
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] emit_len_q;
	logic [LEN_W-1:0] rd_ptr_q;
	logic             last_cr_q;
	logic             drop_q;
	logic [7:0]       rdata_q;
	logic             last_q;
	logic [LEN_W-1:0] emit_len;

	// drop one trailing CR
	assign emit_len = (len_q != '0 && last_cr_q) ? len_q - LEN_W'(1) : len_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[len_q[IDX_W-1:0]] <= in_byte;
		end
		if (cmd.fetch) begin
			rdata_q <= mem[rd_ptr_q[IDX_W-1:0]];
			last_q  <= (rd_ptr_q == emit_len_q - LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			emit_len_q <= '0;
			rd_ptr_q   <= '0;
			last_cr_q  <= 1'b0;
			drop_q     <= 1'b0;
		end else begin
			if (cmd.wr) begin
				len_q     <= len_q + LEN_W'(1);
				last_cr_q <= (in_byte == BYTE_CR);
			end
			if (cmd.ovf) begin
				len_q  <= '0;
				drop_q <= 1'b1;
			end
			if (cmd.lf) begin
				len_q      <= '0;
				drop_q     <= 1'b0;
				emit_len_q <= emit_len;
				rd_ptr_q   <= '0;
			end
			if (cmd.fetch) begin
				rd_ptr_q <= rd_ptr_q + LEN_W'(1);
			end
		end
	end

	assign sts.is_lf      = (in_byte == BYTE_LF);
	assign sts.dropping   = drop_q;
	assign sts.full       = (len_q == LEN_W'(MAX_LINE));
	assign sts.line_empty = (emit_len == '0);
	assign sts.last       = last_q;

	assign out_byte     = rdata_q;
	assign last_of_line = last_q;

endmodule

[rtl/core/nla_ctrl.sv]
// ----------------------------------------------------------------------------
// nla_ctrl
// Handshake controller: takes words while idle, then walks the line store
// out one word per fetch/show pair after a newline.
// ----------------------------------------------------------------------------
module nla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  nla_pkg::nla_sts_t sts,
	output nla_pkg::nla_cmd_t cmd
);
	import nla_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_SHOW  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SHOW);
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		cmd.wr    = acc && !sts.is_lf && !sts.dropping && !sts.full;
		cmd.ovf   = acc && !sts.is_lf && !sts.dropping && sts.full;
		cmd.lf    = acc && sts.is_lf;
		cmd.fetch = (state_q == S_FETCH);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && sts.is_lf && !sts.dropping && !sts.line_empty) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_SHOW;
			end
			S_SHOW: begin
				if (out_ready) begin
					state_d = sts.last ? S_IDLE : S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/newline_line_assembler_unit.sv]
// Flow: a data word is taken while idle; after a newline, FETCH reads the first
// line word from the store into the output register and SHOW presents it; each
// further word passes through FETCH and SHOW once the prior one is taken.
// Throughput: one input word per cycle while idle; no input is taken while a
// line is being emitted.
// Reset: arst_n clears length, drop mode and controller; the store is not cleared.
// ----------------------------------------------------------------------------
// newline_line_assembler_unit
// Gathers received words into lines ended by newline, strips one trailing CR,
// emits non-empty lines with a last marker, drops overlong lines.
// ----------------------------------------------------------------------------
module newline_line_assembler_unit #(
	parameter int unsigned MAX_LINE = nla_pkg::MAX_LINE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_line
);
	import nla_pkg::*;

	nla_cmd_t cmd;
	nla_sts_t sts;

	nla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nla_datapath #(
		.MAX_LINE (MAX_LINE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.sts          (sts),
		.out_byte     (out_byte),
		.last_of_line (last_of_line)
	);

endmodule

[rtl/core/nla_checker.sv]
// ----------------------------------------------------------------------------
// nla_checker
// Port-level checks on the newline line assembler.
// ----------------------------------------------------------------------------
module nla_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_line
);
	import nla_pkg::*;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_line))
		else $error("output word changed while stalled");

	// no input taken while a line is being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during emit");

	// a data word never starts output
	a_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_byte != BYTE_LF |=> !out_valid)
		else $error("output after non-newline word");

	// more words of the line follow, so input stays blocked
	a_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_line |=> !in_ready)
		else $error("input ready in middle of line");

endmodule

bind newline_line_assembler_unit nla_checker u_nla_checker (.*);

[tb/newline_line_assembler_unit_tb.sv]
// ----------------------------------------------------------------------------
// newline_line_assembler_unit_tb
// Drives raw bytes into the line assembler and checks every emitted word and
// its last marker against a behavioral bench framer or typed rows' expectations.
// Covers empty and CR-only lines, full-length lines, overflow and drop mode,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module newline_line_assembler_unit_tb;

	import nla_pkg::*;

	localparam int unsigned MAX_LINE  = MAX_LINE_DEF;
	localparam int unsigned CYC_LIMIT = 200000;
	localparam int unsigned RND_BYTES = 16;
	localparam int unsigned N_ROWS    = 21;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} line_word_t;

	// directed stimulus row; typed rows carry their own expectation
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       emits;
		logic [7:0] t_byte;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [N_ROWS] = '{
		'{BYTE_LF, 1'b1, 1'b0, 8'h00},
		'{BYTE_CR, 1'b1, 1'b0, 8'h00}, '{BYTE_LF, 1'b1, 1'b0, 8'h00},
		'{8'h00, 1'b1, 1'b0, 8'h00}, '{BYTE_LF, 1'b1, 1'b1, 8'h00},
		'{8'hFF, 1'b1, 1'b0, 8'h00}, '{BYTE_LF, 1'b1, 1'b1, 8'hFF},
		'{BYTE_CR, 1'b1, 1'b0, 8'h00}, '{BYTE_CR, 1'b1, 1'b0, 8'h00},
		'{BYTE_LF, 1'b1, 1'b1, BYTE_CR},
		'{8'h41, 1'b1, 1'b0, 8'h00}, '{BYTE_CR, 1'b1, 1'b0, 8'h00},
		'{8'h42, 1'b1, 1'b0, 8'h00}, '{BYTE_LF, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b1, 1'b0, 8'h00}, '{8'h7F, 1'b1, 1'b0, 8'h00},
		'{BYTE_CR, 1'b1, 1'b0, 8'h00}, '{BYTE_LF, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b1, 1'b0, 8'h00}, '{8'hAA, 1'b1, 1'b0, 8'h00},
		'{BYTE_LF, 1'b0, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_line;

	// bench copy of the framer state
	logic [7:0]  line_buf [MAX_LINE];
	int unsigned line_len;
	bit          drop_mode;

	line_word_t  pending_words [$];
	line_word_t  seen_word;
	int unsigned err_cnt;
	int unsigned cycles;
	int unsigned rnd_bytes;
	bit          idle_free;
	int unsigned stall_left;
	int unsigned ready_pick;

	newline_line_assembler_unit #(
		.MAX_LINE(MAX_LINE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_line(last_of_line)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// one byte through the framer; words of a finished line go to pending_words when keep is set
	task automatic frame_line_byte(input logic [7:0] b, input bit keep);
		int unsigned n;
		int unsigned k;
		if (b == BYTE_LF) begin
			if (drop_mode) begin
				drop_mode = 1'b0;
				line_len = 0;
			end else begin
				n = line_len;
				if (n > 0 && line_buf[n - 1] == BYTE_CR)
					n--;
				line_len = 0;
				if (keep) begin
					for (k = 0; k < n; k++)
						pending_words.push_back(line_word_t'{line_buf[k], k + 1 == n});
				end
			end
		end else if (!drop_mode) begin
			if (line_len < MAX_LINE) begin
				line_buf[line_len] = b;
				line_len++;
			end else begin
				// overflow byte: line is lost until the next newline
				line_len = 0;
				drop_mode = 1'b1;
			end
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (idle_free)
			return 0;
		if (r < 70)
			return $urandom_range(0, 1);
		if (r < 95)
			return $urandom_range(2, 4);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit keep);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		frame_line_byte(b, keep);
	endtask

	// hold the input off until every predicted word has been taken
	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic send_line(input int unsigned len, input bit cr_tail);
		int unsigned i;
		logic [7:0] b;
		idle_free = ($urandom_range(0, 4) == 0);
		for (i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == BYTE_LF)
				b = 8'h20;
			if ($urandom_range(0, 15) == 0)
				b = BYTE_CR;
			send_byte(b, 1'b1);
		end
		if (cr_tail)
			send_byte(BYTE_CR, 1'b1);
		send_byte(BYTE_LF, 1'b1);
		rnd_bytes += len + cr_tail + 1;
	endtask

	// random back-pressure on the output side
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 60) begin
				out_ready <= 1'b1;
				stall_left <= $urandom_range(0, 8);
			end else if (ready_pick < 93) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(10, 30);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word %02h last %0b", out_byte, last_of_line));
			end else begin
				seen_word = pending_words.pop_front();
				if (out_byte !== seen_word.data)
					report($sformatf("out_byte %02h, want %02h", out_byte, seen_word.data));
				if (last_of_line !== seen_word.last)
					report($sformatf("last_of_line %0b, want %0b on word %02h",
						last_of_line, seen_word.last, seen_word.data));
			end
		end
	end

	initial begin
		int unsigned r;
		int unsigned i;
		int unsigned pick;
		int unsigned n;
		rnd_bytes = 0;
		line_len = 0;
		drop_mode = 1'b0;
		idle_free = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < N_ROWS; r++) begin
			send_byte(DIR_ROWS[r].b, !DIR_ROWS[r].typed);
			if (DIR_ROWS[r].typed && DIR_ROWS[r].emits)
				pending_words.push_back(line_word_t'{DIR_ROWS[r].t_byte, 1'b1});
		end
		drain_words();

		// full-length lines, overflow and drop mode
		send_line(MAX_LINE, 1'b0);
		send_line(MAX_LINE + 1, 1'b1);    // overflow, then a CR ignored in drop mode
		send_line(2, 1'b1);
		drain_words();

		rnd_bytes = 0;
		while (rnd_bytes < RND_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				send_line($urandom_range(0, 10), $urandom_range(0, 9) < 3);
			end else if (pick < 88) begin
				send_line($urandom_range(11, 20), $urandom_range(0, 9) < 3);
			end else begin
				// noise: raw bytes with stray newlines
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 3) == 0)
						send_byte(BYTE_LF, 1'b1);
					else
						send_byte(8'($urandom_range(0, 255)), 1'b1);
				end
				rnd_bytes += n;
			end
			if ($urandom_range(0, 19) == 0)
				drain_words();
		end
		send_line($urandom_range(1, 5), 1'b0);

		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[newline_line_assembler_unit.f]
rtl/core/nla_pkg.sv
rtl/core/nla_datapath.sv
rtl/core/nla_ctrl.sv
rtl/core/newline_line_assembler_unit.sv
rtl/core/nla_checker.sv
tb/newline_line_assembler_unit_tb.sv
